### hdl/tmba_pkg.sv
// Shared constants and types for the triangle mesh bounding box / area block.
// No dependencies; compiled first.
package tmba_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int AREA_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 32;

  // Triangle geometry
  localparam int NUM_VERTS = 3;
  localparam int NUM_AXES  = 3;

  // Control from the sequencer to the bounding box unit
  typedef struct packed {
    logic start;  // begin a sweep over the latched vertices
    logic first;  // box is empty: vertex A seeds it
  } bbox_ctl_t;

endpackage

### hdl/tmba_if.sv
// Valid/ready channel interfaces for triangle input and accumulator results.
// Depends on tmba_pkg for default widths.
interface tmba_in_if #(
  parameter int COORD_BITS = tmba_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx_in;
  logic signed [COORD_BITS-1:0] cy_in;
  logic signed [COORD_BITS-1:0] cz_in;

  modport source (output valid, ax, ay, az, bx, by, bz, cx_in, cy_in, cz_in,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx_in, cy_in, cz_in,
                  output ready);
endinterface

interface tmba_out_if #(
  parameter int COORD_BITS = tmba_pkg::COORD_BITS_DEF,
  parameter int AREA_BITS  = tmba_pkg::AREA_BITS_DEF,
  parameter int COUNT_BITS = tmba_pkg::COUNT_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;
  logic [AREA_BITS-1:0]         twice_area_total;
  logic [COUNT_BITS-1:0]        triangles_seen;
  logic                         saturated;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, twice_area_total, triangles_seen, saturated,
                  input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, twice_area_total, triangles_seen, saturated,
                  output ready);
endinterface

### hdl/tmba_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing but clk/rst_n; used by the accumulator top level.
module tmba_mul #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N-1:0]   a,
  input  logic [N-1:0]   b,
  output logic           done,
  output logic [2*N-1:0] p
);
  localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N-1:0]     a_r;
  logic [N:0]       hi_r;
  logic [N-1:0]     lo_r;
  logic [N:0]       sum;

  // Partial sum: add multiplicand when the current multiplier bit is set
  assign sum = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(N - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: shift {hi, lo} right one place per step
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (run_r) begin
      hi_r <= {1'b0, sum[N:1]};
      lo_r <= {sum[0], lo_r[N-1:1]};
    end
  end

  assign done = done_r;
  assign p    = {hi_r[N-1:0], lo_r};

endmodule

### hdl/tmba_sqrt.sv
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// Depends on nothing but clk/rst_n; used by the accumulator top level.
module tmba_sqrt #(
  parameter int W = 68
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     rad,
  output logic             done,
  output logic [W/2-1:0]   root
);
  localparam int Q     = W / 2;
  localparam int CNT_W = (Q > 1) ? $clog2(Q) : 1;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rad_r;
  logic [Q-1:0]     rem_r;
  logic [Q-1:0]     root_r;
  logic [Q+1:0]     rs;
  logic [Q+1:0]     trial;
  logic             ge;

  // Bring down the next two radicand bits and try root*4+1
  // (remainder before the last step stays below 2^Q; the final one is not kept)
  assign rs    = {rem_r, rad_r[W-1:W-2]};
  assign trial = {root_r, 2'b01};
  assign ge    = (rs >= trial);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(Q - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[W-3:0], 2'b00};
      rem_r  <= Q'(ge ? (rs - trial) : rs);
      root_r <= {root_r[Q-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hdl/tmba_bbox.sv
// Running axis-aligned bounding box, widened by one vertex per cycle.
// Depends on tmba_pkg (bbox_ctl_t, vertex/axis counts).
module tmba_bbox #(
  parameter int COORD_BITS = tmba_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tmba_pkg::bbox_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] vtx     [tmba_pkg::NUM_VERTS][tmba_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] box_min [tmba_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] box_max [tmba_pkg::NUM_AXES]
);
  import tmba_pkg::*;

  localparam int IDX_W = $clog2(NUM_VERTS);

  logic                         run_r;
  logic                         first_r;
  logic [IDX_W-1:0]             idx_r;
  logic signed [COORD_BITS-1:0] min_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] max_r [NUM_AXES];
  logic                         seed;

  // Vertex A of the very first triangle seeds the box
  assign seed = first_r && (idx_r == '0);

  // Sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      first_r <= 1'b0;
      idx_r   <= '0;
    end else if (ctl.start) begin
      run_r   <= 1'b1;
      first_r <= ctl.first;
      idx_r   <= '0;
    end else if (run_r) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == IDX_W'(NUM_VERTS - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Min/max update, all three axes of one vertex per cycle
  always_ff @(posedge clk) begin
    if (run_r) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (seed) begin
          min_r[i] <= vtx[idx_r][i];
          max_r[i] <= vtx[idx_r][i];
        end else begin
          if (vtx[idx_r][i] < min_r[i]) min_r[i] <= vtx[idx_r][i];
          if (vtx[idx_r][i] > max_r[i]) max_r[i] <= vtx[idx_r][i];
        end
      end
    end
  end

  assign box_min = min_r;
  assign box_max = max_r;

endmodule

### hdl/triangle_mesh_bbox_area_accumulator.sv
// Triangle mesh accumulator: takes one triangle per transaction and returns one result
// holding the running bounding box, the saturating sum of twice the triangle areas
// (floor of |AB x AC|) and the saturating triangle count. One triangle is processed
// at a time: the edge vectors go through the bit-serial cross-product multipliers, the
// cross components through the bit-serial squaring multipliers and their sum through
// the one-bit-per-cycle square root, with sequencing and handoff states in between.
// The result waits in S_DONE until the output slot is free. Input is ready again in the
// same cycle as the result appears, so a new triangle is only taken once the last one
// is finished. A finished result sits in the output register while the next triangle
// is accepted.
// Depends on tmba_pkg, tmba_if, tmba_mul, tmba_sqrt and tmba_bbox.
module triangle_mesh_bbox_area_accumulator #(
  parameter int COORD_BITS = tmba_pkg::COORD_BITS_DEF,
  parameter int AREA_BITS  = tmba_pkg::AREA_BITS_DEF,
  parameter int COUNT_BITS = tmba_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tmba_in_if.sink   in_tri,
  tmba_out_if.source out_res
);
  import tmba_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int D_W    = C + 1;          // edge vector component
  localparam int P1_W   = 2 * C;          // |edge| * |edge|
  localparam int SP_W   = P1_W + 1;       // signed product
  localparam int X_W    = SP_W + 1;       // signed cross component
  localparam int M_W    = X_W - 1;        // cross component magnitude
  localparam int P2_W   = 2 * M_W;        // squared magnitude
  localparam int S1_W   = P2_W + 1;       // sum of two squares
  localparam int RAD_W  = P2_W + 2;       // sum of three squares
  localparam int ROOT_W = RAD_W / 2;
  localparam int SUM_W  = ((AREA_BITS > ROOT_W) ? AREA_BITS : ROOT_W) + 1;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DIFF    = 14'b00000000000010,
    S_MUL1GO  = 14'b00000000000100,
    S_MUL1    = 14'b00000000001000,
    S_SIGN    = 14'b00000000010000,
    S_CROSS   = 14'b00000000100000,
    S_MAG     = 14'b00000001000000,
    S_MUL2GO  = 14'b00000010000000,
    S_MUL2    = 14'b00000100000000,
    S_SUM1    = 14'b00001000000000,
    S_SUM2    = 14'b00010000000000,
    S_ROOTGO  = 14'b00100000000000,
    S_ROOT    = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [C-1:0]    vtx_r   [NUM_VERTS][NUM_AXES];
  logic signed [D_W-1:0]  bdiff_r [NUM_AXES];
  logic signed [D_W-1:0]  cdiff_r [NUM_AXES];
  logic [C-1:0]           bmag    [NUM_AXES];
  logic [C-1:0]           cmag    [NUM_AXES];
  logic [P1_W-1:0]        prod1   [NUM_AXES];
  logic [P1_W-1:0]        prod2   [NUM_AXES];
  logic                   sg1     [NUM_AXES];
  logic                   sg2     [NUM_AXES];
  logic signed [SP_W-1:0] sp1_r   [NUM_AXES];
  logic signed [SP_W-1:0] sp2_r   [NUM_AXES];
  logic signed [X_W-1:0]  cross_r [NUM_AXES];
  logic [M_W-1:0]         mag_r   [NUM_AXES];
  logic [P2_W-1:0]        sq      [NUM_AXES];
  logic [2*NUM_AXES-1:0]  mul1_done;
  logic [NUM_AXES-1:0]    mul2_done;
  logic [S1_W-1:0]        sum01_r;
  logic [RAD_W-1:0]       rad_r;
  logic                   root_done;
  logic [ROOT_W-1:0]      root_val;

  logic [AREA_BITS-1:0]   area_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic                   sat_r;
  logic [SUM_W-1:0]       area_ext;
  logic                   area_ovf;
  logic                   count_full;
  logic                   slot_free;
  logic                   out_valid_r;

  bbox_ctl_t              bbox_ctl;
  logic signed [C-1:0]    box_min [NUM_AXES];
  logic signed [C-1:0]    box_max [NUM_AXES];
  logic signed [C-1:0]    omin_r  [NUM_AXES];
  logic signed [C-1:0]    omax_r  [NUM_AXES];

  assign in_tri.ready = rst_n && (state_r == S_IDLE);
  assign slot_free    = !out_valid_r || out_res.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tri.valid) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL1GO;
      S_MUL1GO: state_nxt = S_MUL1;
      S_MUL1:   if (&mul1_done) state_nxt = S_SIGN;
      S_SIGN:   state_nxt = S_CROSS;
      S_CROSS:  state_nxt = S_MAG;
      S_MAG:    state_nxt = S_MUL2GO;
      S_MUL2GO: state_nxt = S_MUL2;
      S_MUL2:   if (&mul2_done) state_nxt = S_SUM1;
      S_SUM1:   state_nxt = S_SUM2;
      S_SUM2:   state_nxt = S_ROOTGO;
      S_ROOTGO: state_nxt = S_ROOT;
      S_ROOT:   if (root_done) state_nxt = S_DONE;
      S_DONE:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_tri.valid && in_tri.ready) begin
      vtx_r[0][0] <= in_tri.ax;
      vtx_r[0][1] <= in_tri.ay;
      vtx_r[0][2] <= in_tri.az;
      vtx_r[1][0] <= in_tri.bx;
      vtx_r[1][1] <= in_tri.by;
      vtx_r[1][2] <= in_tri.bz;
      vtx_r[2][0] <= in_tri.cx_in;
      vtx_r[2][1] <= in_tri.cy_in;
      vtx_r[2][2] <= in_tri.cz_in;
    end
  end

  // Bounding box sweep starts once the vertices are latched
  assign bbox_ctl.start = (state_r == S_DIFF);
  assign bbox_ctl.first = (count_r == '0);

  tmba_bbox #(.COORD_BITS(C)) u_bbox (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bbox_ctl),
    .vtx     (vtx_r),
    .box_min (box_min),
    .box_max (box_max)
  );

  // Edge vectors AB and AC, and their magnitudes
  always_ff @(posedge clk) begin
    if (state_r == S_DIFF) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        bdiff_r[i] <= D_W'(vtx_r[1][i]) - D_W'(vtx_r[0][i]);
        cdiff_r[i] <= D_W'(vtx_r[2][i]) - D_W'(vtx_r[0][i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      bmag[i] = bdiff_r[i][D_W-1] ? C'(-bdiff_r[i]) : C'(bdiff_r[i]);
      cmag[i] = cdiff_r[i][D_W-1] ? C'(-cdiff_r[i]) : C'(cdiff_r[i]);
    end
  end

  // Cross product terms: component j = b[j+1]*c[j+2] - b[j+2]*c[j+1]
  for (genvar j = 0; j < NUM_AXES; j++) begin : g_cross
    localparam int J1 = (j + 1) % NUM_AXES;
    localparam int J2 = (j + 2) % NUM_AXES;

    assign sg1[j] = bdiff_r[J1][D_W-1] ^ cdiff_r[J2][D_W-1];
    assign sg2[j] = bdiff_r[J2][D_W-1] ^ cdiff_r[J1][D_W-1];

    tmba_mul #(.N(C)) u_mul_a (
      .clk   (clk),
      .rst_n (rst_n),
      .start (state_r == S_MUL1GO),
      .a     (bmag[J1]),
      .b     (cmag[J2]),
      .done  (mul1_done[2*j]),
      .p     (prod1[j])
    );

    tmba_mul #(.N(C)) u_mul_b (
      .clk   (clk),
      .rst_n (rst_n),
      .start (state_r == S_MUL1GO),
      .a     (bmag[J2]),
      .b     (cmag[J1]),
      .done  (mul1_done[2*j+1]),
      .p     (prod2[j])
    );

    tmba_mul #(.N(M_W)) u_mul_sq (
      .clk   (clk),
      .rst_n (rst_n),
      .start (state_r == S_MUL2GO),
      .a     (mag_r[j]),
      .b     (mag_r[j]),
      .done  (mul2_done[j]),
      .p     (sq[j])
    );
  end

  // Signed products, cross components, magnitudes: one step per state
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (state_r == S_SIGN) begin
        sp1_r[i] <= sg1[i] ? (SP_W'(0) - SP_W'(prod1[i])) : SP_W'(prod1[i]);
        sp2_r[i] <= sg2[i] ? (SP_W'(0) - SP_W'(prod2[i])) : SP_W'(prod2[i]);
      end
      if (state_r == S_CROSS) begin
        cross_r[i] <= X_W'(sp1_r[i]) - X_W'(sp2_r[i]);
      end
      if (state_r == S_MAG) begin
        mag_r[i] <= cross_r[i][X_W-1] ? M_W'(-cross_r[i]) : M_W'(cross_r[i]);
      end
    end
  end

  // Sum of the squared components
  always_ff @(posedge clk) begin
    if (state_r == S_SUM1) begin
      sum01_r <= S1_W'(sq[0]) + S1_W'(sq[1]);
    end
    if (state_r == S_SUM2) begin
      rad_r <= RAD_W'(sum01_r) + RAD_W'(sq[2]);
    end
  end

  tmba_sqrt #(.W(RAD_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_ROOTGO),
    .rad   (rad_r),
    .done  (root_done),
    .root  (root_val)
  );

  // Saturating accumulation
  assign area_ext   = SUM_W'(area_r) + SUM_W'(root_val);
  assign area_ovf   = area_ext > SUM_W'({AREA_BITS{1'b1}});
  assign count_full = &count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r  <= '0;
      count_r <= '0;
      sat_r   <= 1'b0;
    end else if ((state_r == S_DONE) && slot_free) begin
      area_r  <= area_ovf ? {AREA_BITS{1'b1}} : area_ext[AREA_BITS-1:0];
      count_r <= count_full ? count_r : count_r + 1'b1;
      if (area_ovf || count_full) sat_r <= 1'b1;
    end
  end

  // Output register; the box is copied since the next sweep may start early
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && slot_free) begin
      omin_r <= box_min;
      omax_r <= box_max;
    end
  end

  // Sum, count and flag only change when the output slot is free
  assign out_res.valid            = out_valid_r;
  assign out_res.box_min_x        = omin_r[0];
  assign out_res.box_min_y        = omin_r[1];
  assign out_res.box_min_z        = omin_r[2];
  assign out_res.box_max_x        = omax_r[0];
  assign out_res.box_max_y        = omax_r[1];
  assign out_res.box_max_z        = omax_r[2];
  assign out_res.twice_area_total = area_r;
  assign out_res.triangles_seen   = count_r;
  assign out_res.saturated        = sat_r;

`ifndef SYNTHESIS
  // Saturation flag is sticky
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |=> sat_r)
    else $error("saturation flag cleared");

  // Area sum never decreases
  a_area_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> area_r >= $past(area_r))
    else $error("area sum decreased");

  // All cross-product multipliers finish together
  a_mul1_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (|mul1_done) |-> (&mul1_done))
    else $error("cross-product multipliers out of step");

  // Square root completes only while the sequencer waits for it
  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("square root done outside its wait state");
`endif

endmodule

### sim/tb.sv
// Testbench for triangle_mesh_bbox_area_accumulator: random and directed triangles in,
// running bounding box / twice-area sum / count checked against a built-in tracker.
// Depends on tmba_pkg, tmba_if and the block itself.
`timescale 1ns / 100ps

module tb;

  localparam int CW = tmba_pkg::COORD_BITS_DEF;
  localparam int AW = tmba_pkg::AREA_BITS_DEF;
  localparam int NW = tmba_pkg::COUNT_BITS_DEF;
  localparam int NV = tmba_pkg::NUM_VERTS;
  localparam int NA = tmba_pkg::NUM_AXES;
  localparam int LATENCY     = 5 * CW + 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_FACETS = 1750;
  localparam int NUM_PHASES  = 4;

  typedef logic signed [CW-1:0] coord_t;
  // vertex k, axis a sits at index NA*k + a
  typedef coord_t facet_t [NV*NA];

  typedef struct {
    coord_t          lo [NA];
    coord_t          hi [NA];
    logic [AW-1:0]   area;
    logic [NW-1:0]   count;
    logic            sat;
  } mesh_stats_t;

  // Tracks box, area sum and count; queues the stats each accepted facet should produce
  class mesh_tracker;
    coord_t          box_lo [NA];
    coord_t          box_hi [NA];
    logic [AW-1:0]   area_sum;
    logic [NW-1:0]   facet_count;
    logic            sat;
    mesh_stats_t     stats_due [$];
    int              mismatches;

    function void clear();
      foreach (box_lo[a]) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      area_sum    = '0;
      facet_count = '0;
      sat         = 1'b0;
      mismatches  = 0;
      stats_due.delete();
    endfunction

    function void take_facet(facet_t f);
      longint        p [NV*NA];
      longint        b0, b1, b2, c0, c1, c2, nx, ny, nz;
      logic [127:0]  sum_sq, sq;
      logic [63:0]   root, trial, amax;
      mesh_stats_t   s;
      foreach (f[i]) p[i] = f[i];

      // first facet seeds the box with vertex A
      if (facet_count == '0) begin
        for (int a = 0; a < NA; a++) begin
          box_lo[a] = f[a];
          box_hi[a] = f[a];
        end
      end
      for (int k = 0; k < NV; k++) begin
        for (int a = 0; a < NA; a++) begin
          if (f[NA*k + a] < box_lo[a]) box_lo[a] = f[NA*k + a];
          if (f[NA*k + a] > box_hi[a]) box_hi[a] = f[NA*k + a];
        end
      end

      // |AB x AC|, floored
      b0 = p[3] - p[0]; b1 = p[4] - p[1]; b2 = p[5] - p[2];
      c0 = p[6] - p[0]; c1 = p[7] - p[1]; c2 = p[8] - p[2];
      nx = b1 * c2 - b2 * c1;
      ny = b2 * c0 - b0 * c2;
      nz = b0 * c1 - b1 * c0;
      if (nx < 0) nx = -nx;
      if (ny < 0) ny = -ny;
      if (nz < 0) nz = -nz;
      sum_sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
      root = '0;
      for (int b = 53; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        sq = {64'd0, trial} * {64'd0, trial};
        if (sq <= sum_sq) root = trial;
      end

      // saturating sum and count, sticky flag
      amax = (64'd1 << AW) - 64'd1;
      if (root > amax - 64'(area_sum)) begin
        area_sum = amax[AW-1:0];
        sat = 1'b1;
      end else begin
        area_sum = area_sum + root[AW-1:0];
      end
      if (facet_count == '1) sat = 1'b1;
      else facet_count = facet_count + 1'b1;

      s.lo    = box_lo;
      s.hi    = box_hi;
      s.area  = area_sum;
      s.count = facet_count;
      s.sat   = sat;
      stats_due = {stats_due, s};
    endfunction

    function void cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_stats(mesh_stats_t got);
      mesh_stats_t want;
      string       axis_name [NA];
      axis_name = '{"x", "y", "z"};
      if (stats_due.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        mismatches++;
        return;
      end
      want = stats_due.pop_front();
      for (int a = 0; a < NA; a++) begin
        cmp_field({"box_min_", axis_name[a]}, want.lo[a], got.lo[a]);
        cmp_field({"box_max_", axis_name[a]}, want.hi[a], got.hi[a]);
      end
      cmp_field("twice_area_total", {16'd0, want.area}, {16'd0, got.area});
      cmp_field("triangles_seen", {32'd0, want.count}, {32'd0, got.count});
      cmp_field("saturated", {63'd0, want.sat}, {63'd0, got.sat});
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycles;
  mesh_tracker tracker;

  tmba_in_if  in_if ();
  tmba_out_if out_if ();

  triangle_mesh_bbox_area_accumulator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tri  (in_if),
    .out_res (out_if)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, decided at the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    mesh_stats_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.lo[0] = out_if.box_min_x;
      got.lo[1] = out_if.box_min_y;
      got.lo[2] = out_if.box_min_z;
      got.hi[0] = out_if.box_max_x;
      got.hi[1] = out_if.box_max_y;
      got.hi[2] = out_if.box_max_z;
      got.area  = out_if.twice_area_total;
      got.count = out_if.triangles_seen;
      got.sat   = out_if.saturated;
      tracker.check_stats(got);
    end
  end

  // Drive one facet; starts and ends at a falling edge, valid stays high when no gap follows
  task automatic send_facet(input facet_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ax    <= f[0];
    in_if.ay    <= f[1];
    in_if.az    <= f[2];
    in_if.bx    <= f[3];
    in_if.by    <= f[4];
    in_if.bz    <= f[5];
    in_if.cx_in <= f[6];
    in_if.cy_in <= f[7];
    in_if.cz_in <= f[8];
    do @(posedge clk); while (!in_if.ready);
    tracker.take_facet(f);
    @(negedge clk);
  endtask

  initial begin
    facet_t f;
    int     send_pcts [NUM_PHASES];
    int     recv_pcts [NUM_PHASES];
    int     kind, ctr, span, scale;
    coord_t picks [4];

    send_pcts = '{0, 52, 0, 26};
    recv_pcts = '{0, 0, 52, 26};
    picks     = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tracker = new();
    tracker.clear();

    in_if.valid = 1'b0;
    in_if.ax    = '0;
    in_if.ay    = '0;
    in_if.az    = '0;
    in_if.bx    = '0;
    in_if.by    = '0;
    in_if.bz    = '0;
    in_if.cx_in = '0;
    in_if.cy_in = '0;
    in_if.cz_in = '0;

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first facet seeds the box from A, then B and C widen it both ways
    send_facet('{0, 0, 0, 32767, -32768, 100, -32768, 32767, -100});
    // point-like degenerate facets at both extremes
    send_facet('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    send_facet('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    // collinear vertices: zero area, box already at full range and unchanged
    send_facet('{0, 0, 0, 1, 2, 3, 2, 4, 6});
    send_facet('{5, 5, 5, 5, 5, 5, -7, 9, 1});
    // largest facet across the cube, both windings
    send_facet('{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767});
    send_facet('{32767, -32768, -32768, -32768, -32768, 32767, -32768, 32767, -32768});
    // full-span right triangles in each axis plane
    send_facet('{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0});
    send_facet('{0, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767});
    send_facet('{-32768, 0, -32768, -32768, 0, 32767, 32767, 0, -32768});
    // tiny facets: root of 2 floors to 1, unit square half
    send_facet('{0, 0, 0, 1, 0, 0, 0, 1, 1});
    send_facet('{1, 1, 1, 2, 1, 1, 1, 2, 1});
    // alternating bit patterns, then a mix of extremes and small values
    send_facet('{21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845});
    send_facet('{-1, -2, -3, -32768, 32767, -1, 1, -32768, 32767});

    // Random: phases of input gaps and output back-pressure, facets of several shapes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int n = 0; n < RAND_FACETS / NUM_PHASES; n++) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          // anywhere in the grid
          foreach (f[i]) f[i] = coord_t'($urandom);
        end else if (kind < 55) begin
          // small facet around a random center
          for (int a = 0; a < NA; a++) begin
            ctr = int'($urandom_range(65503)) - 32752;
            for (int k = 0; k < NV; k++) f[NA*k + a] = coord_t'(ctr + int'($urandom_range(30)) - 15);
          end
        end else if (kind < 70) begin
          // corners and near-zero values
          foreach (f[i]) f[i] = picks[$urandom_range(3)];
        end else if (kind < 85) begin
          // collinear: C = A + k*(B - A)
          scale = int'($urandom_range(10)) - 5;
          for (int a = 0; a < NA; a++) begin
            ctr  = int'($urandom_range(2000)) - 1000;
            span = int'($urandom_range(200)) - 100;
            f[a]      = coord_t'(ctr);
            f[NA + a] = coord_t'(ctr + span);
            f[2*NA + a] = coord_t'(ctr + scale * span);
          end
        end else begin
          // medium range
          foreach (f[i]) f[i] = coord_t'(int'($urandom_range(2047)) - 1024);
        end
        send_facet(f);
      end
    end
    in_if.valid <= 1'b0;

    // drain, then let the block settle
    while (tracker.stats_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
